### design/dltq_pkg.sv
// shared types and constants for the delta list timeout queue
// no dependencies

package dltq_pkg;

   localparam int ID_W     = 16;
   localparam int OWNER_W  = 8;
   localparam int DELTA_W  = 24;
   localparam int TICK_W   = 16;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;

   localparam logic [TICK_W-1:0] TICK_RESET = 16'd10;

   // register index of tick_interval on the csr port
   localparam logic REG_TICK = 1'b0;

   localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SCHEDULE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNSCHEDULE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SCHEDULED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

   typedef struct packed {
      logic [ID_W-1:0]    id;
      logic [OWNER_W-1:0] owner;
      logic [DELTA_W-1:0] delta;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type data;
   } mem_wr_type;

endpackage

### design/dltq_mem.sv
// entry memory of the delta list: one write port, one read port, registered read
// depends on dltq_pkg

module dltq_mem
   import dltq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                       clock,
   input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] rd_addr,
   output entry_type                                  rd_data,
   input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] wr_addr,
   input  mem_wr_type                                 wr
);

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dltq_ctrl.sv
// sequencer of the delta list: walks, shifts and repairs entries through the memory,
// holds the entry count and the result register; depends on dltq_pkg

module dltq_ctrl
   import dltq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [TICK_W-1:0]     tick_interval,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [ID_W-1:0]       req_timeout_id,
   input  logic [OWNER_W-1:0]    req_owner,
   input  logic [DELTA_W-1:0]    req_interval,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ID_W-1:0]       rsp_expired_id,
   output logic [OWNER_W-1:0]    rsp_expired_owner,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] mem_rd_addr,
   input  entry_type             mem_rd_data,
   output logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] mem_wr_addr,
   output mem_wr_type            mem_wr
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_HEAD = 8'b0000_0010,
      S_WALK = 8'b0000_0100,
      S_FIND = 8'b0000_1000,
      S_SHUP = 8'b0001_0000,
      S_SHDN = 8'b0010_0000,
      S_PUT  = 8'b0100_0000,
      S_FIN  = 8'b1000_0000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [DELTA_W-1:0]   rem_ff, rem_in;
   logic [DELTA_W-1:0]   gone_ff, gone_in;
   logic                 fix_ff, fix_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [OWNER_W-1:0]   owner_ff, owner_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [ID_W-1:0]      res_id_ff, res_id_in;
   logic [OWNER_W-1:0]   res_owner_ff, res_owner_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [OWNER_W-1:0]   rsp_owner_ff, rsp_owner_in;

   logic [CW-1:0]        rd_idx;
   logic [CW-1:0]        wr_idx;
   logic                 wr_en;
   entry_type            wr_data;
   logic [CW-1:0]        idx_nxt;
   logic [CW-1:0]        idx_prv;
   logic [CW-1:0]        idx_nn;
   logic [DELTA_W-1:0]   tick_ext;
   logic [DELTA_W-1:0]   head_val;
   logic [DELTA_W:0]     rep_sum;
   logic [DELTA_W-1:0]   rep_val;
   logic                 match;
   logic                 out_free;

   assign idx_nxt  = idx_ff + 1'b1;
   assign idx_prv  = idx_ff - 1'b1;
   assign idx_nn   = idx_ff + CW'(2);
   assign tick_ext = DELTA_W'(tick_interval);
   assign head_val = (mem_rd_data.delta > tick_ext) ? (mem_rd_data.delta - tick_ext)
                                                    : '0;
   assign rep_sum  = {1'b0, mem_rd_data.delta} + {1'b0, gone_ff};
   assign rep_val  = rep_sum[DELTA_W] ? '1 : rep_sum[DELTA_W-1:0];
   assign match    = (mem_rd_data.id == id_ff) && (mem_rd_data.owner == owner_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      gone_in       = gone_ff;
      fix_in        = fix_ff;
      id_in         = id_ff;
      owner_in      = owner_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_owner_in  = res_owner_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_owner_in  = rsp_owner_ff;
      rd_idx        = '0;
      wr_idx        = '0;
      wr_en         = 1'b0;
      wr_data       = mem_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               id_in        = req_timeout_id;
               owner_in     = req_owner;
               rem_in       = req_interval;
               idx_in       = '0;
               fix_in       = 1'b0;
               res_id_in    = '0;
               res_owner_in = '0;
               unique case (req_cmd)
                  CMD_TICK: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_NONE;
                        state_in      = S_FIN;
                     end else begin
                        state_in = S_HEAD;
                     end
                  end
                  CMD_SCHEDULE: begin
                     if (count_ff == DEPTH_C) begin
                        res_status_in = ST_FULL;
                        state_in      = S_FIN;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  CMD_UNSCHEDULE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_NOT_FOUND;
                        state_in      = S_FIN;
                     end else begin
                        state_in = S_FIND;
                     end
                  end
                  default: begin
                     res_status_in = ST_NONE;
                     state_in      = S_FIN;
                  end
               endcase
            end
         end
         S_HEAD: begin
            if (head_val != '0) begin
               wr_en         = 1'b1;
               wr_idx        = '0;
               wr_data.delta = head_val;
               res_status_in = ST_NONE;
               state_in      = S_FIN;
            end else begin
               res_status_in = ST_EXPIRED;
               res_id_in     = mem_rd_data.id;
               res_owner_in  = mem_rd_data.owner;
               if (count_ff > CW'(1)) begin
                  idx_in   = '0;
                  rd_idx   = CW'(1);
                  fix_in   = 1'b0;
                  state_in = S_SHDN;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = S_FIN;
               end
            end
         end
         S_SHDN: begin
            wr_en  = 1'b1;
            wr_idx = idx_ff;
            if (fix_ff) begin
               wr_data.delta = rep_val;
            end
            fix_in = 1'b0;
            if (idx_nn < count_ff) begin
               idx_in = idx_nxt;
               rd_idx = idx_nn;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_FIN;
            end
         end
         S_FIND: begin
            if (match) begin
               res_status_in = ST_REMOVED;
               if (idx_nxt < count_ff) begin
                  gone_in  = mem_rd_data.delta;
                  fix_in   = 1'b1;
                  rd_idx   = idx_nxt;
                  state_in = S_SHDN;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = S_FIN;
               end
            end else if (idx_nxt < count_ff) begin
               idx_in = idx_nxt;
               rd_idx = idx_nxt;
            end else begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_FIN;
            end
         end
         S_WALK: begin
            if ((idx_ff < count_ff) && (mem_rd_data.delta <= rem_ff)) begin
               rem_in = rem_ff - mem_rd_data.delta;
               idx_in = idx_nxt;
               rd_idx = idx_nxt;
            end else begin
               pos_in = idx_ff;
               if (idx_ff == count_ff) begin
                  state_in = S_PUT;
               end else begin
                  idx_in   = count_ff - 1'b1;
                  rd_idx   = count_ff - 1'b1;
                  state_in = S_SHUP;
               end
            end
         end
         S_SHUP: begin
            wr_en  = 1'b1;
            wr_idx = idx_nxt;
            if (idx_ff == pos_ff) begin
               wr_data.delta = mem_rd_data.delta - rem_ff;
               state_in      = S_PUT;
            end else begin
               idx_in = idx_prv;
               rd_idx = idx_prv;
            end
         end
         S_PUT: begin
            wr_en         = 1'b1;
            wr_idx        = pos_ff;
            wr_data       = '{id: id_ff, owner: owner_ff, delta: rem_ff};
            count_in      = count_ff + 1'b1;
            res_status_in = ST_SCHEDULED;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_owner_in  = res_owner_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      rem_ff        <= rem_in;
      gone_ff       <= gone_in;
      fix_ff        <= fix_in;
      id_ff         <= id_in;
      owner_ff      <= owner_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_owner_ff  <= res_owner_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_owner_ff  <= rsp_owner_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired_id    = rsp_id_ff;
   assign rsp_expired_owner = rsp_owner_ff;
   assign mem_rd_addr       = rd_idx[AW-1:0];
   assign mem_wr_addr       = wr_idx[AW-1:0];
   assign mem_wr            = '{en: wr_en, data: wr_data};

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("accepted item did not start processing");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> wr_idx <= count_ff)
      else $error("memory write beyond the live list");

   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && res_status_ff == ST_FULL |-> count_ff == DEPTH_C)
      else $error("schedule refused while table not full");

   a_expired_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_EXPIRED |->
         rsp_id_ff == '0 && rsp_owner_ff == '0)
      else $error("expired fields set on a non-expiry result");

endmodule

### design/delta_list_timeout_queue_top.sv
// Timeout queue kept as a sorted delta list in a single entry memory with registered
// read. One item is processed at a time and every command returns exactly one result
// item. All work goes through one memory read and at most one memory write per cycle.
// A tick reads the head and lowers its delta by tick_interval; when the head expires
// the list is shifted down. A tick on an empty list, an unused command, an unschedule
// on an empty list and a refused schedule go straight to the result. A schedule walks
// to the insert point, then shifts the tail up; an unschedule searches, then shifts
// down with successor repair. Before returning to idle the block waits while the
// previous result is still held in the output register by the receiver.
// The finished result sits in an output register, so the next item is accepted while
// it waits. tick_interval is register 0 on the csr port (reset value 10).
// depends on dltq_pkg, dltq_mem and dltq_ctrl

module delta_list_timeout_queue_top
   import dltq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [ID_W-1:0]      req_timeout_id,
   input  logic [OWNER_W-1:0]   req_owner,
   input  logic [DELTA_W-1:0]   req_interval,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [ID_W-1:0]      rsp_expired_id,
   output logic [OWNER_W-1:0]   rsp_expired_owner,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              csr_wr;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   entry_type         rd_data;
   mem_wr_type        wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign tick_in = (csr_wr && (paddr[2] == REG_TICK)) ? pwdata[TICK_W-1:0] : tick_ff;
   assign prdata = (paddr[2] == REG_TICK) ? 32'(tick_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= TICK_RESET;
      end else begin
         tick_ff <= tick_in;
      end
   end

   dltq_mem #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (wr_addr),
      .wr      (wr)
   );

   dltq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .tick_interval     (tick_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_timeout_id    (req_timeout_id),
      .req_owner         (req_owner),
      .req_interval      (req_interval),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_expired_id    (rsp_expired_id),
      .rsp_expired_owner (rsp_expired_owner),
      .mem_rd_addr       (rd_addr),
      .mem_rd_data       (rd_data),
      .mem_wr_addr       (wr_addr),
      .mem_wr            (wr)
   );

endmodule
